// ===== rtl/agc_pkg.sv =====
`default_nettype none
package agc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RES_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int COEF_W     = 24;
    localparam int LVL_W      = 16;
    localparam int LVL_FRAC   = 35;
    localparam int ENV_STEPS  = 24;
    localparam int GAIN_STEPS = 16;
    localparam int CNT_W      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXGAIN = 3'd4;

    localparam logic [COEF_W-1:0] ATTACK_RST  = 24'd16431303;
    localparam logic [COEF_W-1:0] RELEASE_RST = 24'd16771392;
    localparam logic [LVL_W-1:0]  TARGET_RST  = 16'd23593;
    localparam logic [LVL_W-1:0]  MAKEUP_RST  = 16'd10650;
    localparam logic [LVL_W-1:0]  MAXGAIN_RST = 16'd24576;
    localparam logic [LVL_W-1:0]  GAIN_MIN    = 16'd256;
    localparam logic [RES_W-1:0]  RES_MAX     = 15'd32767;

    localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
    localparam logic [63:0] DRIVE_Q30 = 64'd3006477107;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENV_MUL,
        S_ENV_FIN,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_POS,
        S_ROM_LO,
        S_ROM_HI,
        S_INTERP,
        S_ROUND,
        S_OUT
    } state_t;

    // Elaboration-time long division, one quotient bit per step.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Elaboration-time tanh in Q30: series on z/64, then six doublings.
    function automatic logic [63:0] tanh_q30(input logic [63:0] z);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] a3;
        logic [63:0] a5;
        logic [63:0] a7;
        logic [63:0] t;
        logic [63:0] den;
        a  = (z + 64'd32) >> 6;
        a2 = (a * a) >> 30;
        a3 = (a2 * a) >> 30;
        a5 = (a3 * a2) >> 30;
        a7 = (a5 * a2) >> 30;
        t  = a - a3 / 64'd3;
        t  = t + (64'd2 * a5) / 64'd15;
        t  = t - (64'd17 * a7) / 64'd315;
        for (int i = 0; i < 6; i++)
        begin
            if (t > ONE_Q30)
            begin
                t = ONE_Q30;
            end
            den = ONE_Q30 + ((t * t) >> 30);
            t   = udiv64(t << 31, den);
        end
        if (t > ONE_Q30)
        begin
            t = ONE_Q30;
        end
        return t;
    endfunction

    // Limiter table entry for argument z (Q30), normalized to tanh(drive).
    function automatic logic [RES_W-1:0] lim_entry(input logic [63:0] z);
        logic [63:0] norm;
        logic [63:0] v;
        norm = tanh_q30(DRIVE_Q30);
        if (norm == 64'd0)
        begin
            norm = 64'd1;
        end
        v = udiv64(tanh_q30(z) * 64'd32767 + norm / 64'd2, norm);
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[RES_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/agc_if.sv =====
`default_nettype none
interface agc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [agc_pkg::SAMPLE_W-1:0] sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface agc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [agc_pkg::SAMPLE_W-1:0] sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

interface agc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [agc_pkg::CFG_IDX_W-1:0]     index;
    logic [agc_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/agc_sdiv.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module agc_sdiv #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 25
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quot
);
    localparam int CW = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        trial     = {rem_reg, q_reg[DVD_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            q_next   = {q_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

// ===== rtl/agc_with_soft_limiter_top.sv =====
`default_nettype none
// Channel   Dir  Payload                 Role
// smp_in    in   sample_in  (s16)        audio sample word
// smp_out   out  sample_out (s16)        limited sample word, one per input
// cfg       in   index (3), data (24)    register write word, always ready
//
// One sample at a time; the pace is set by the bit-serial shift-add
// multiplier (24 envelope steps, then 2 x 16 gain steps) and by the
// one-bit-per-cycle gain divider.
// Reset clears the control state and loads the register defaults and the
// initial envelope. A finished word waits in the output register; a new
// sample is taken while it waits, and processing holds before the output
// stage until the register frees.
module agc_with_soft_limiter_top #(
    parameter int LIMITER_TABLE_DEPTH = 1024,
    parameter int ENV_FRACTION_BITS   = 24
) (
    input wire logic  clk,
    input wire logic  rst_n,
    agc_in_if.sink    smp_in,
    agc_out_if.source smp_out,
    agc_cfg_if.sink   cfg
);
    localparam int E      = ENV_FRACTION_BITS;
    localparam int D      = LIMITER_TABLE_DEPTH;
    localparam int IDX_W  = $clog2(D + 1);
    localparam int DVD_W  = E + 8;
    localparam int DVS_W  = E + 1;
    localparam int MW     = (E + 26 > 50) ? (E + 26) : 50;
    localparam int POS_W  = agc_pkg::LVL_FRAC + IDX_W;
    localparam int PROD_W = agc_pkg::RES_W + agc_pkg::LVL_FRAC;
    localparam int CNT_W  = agc_pkg::CNT_W;
    localparam int RW     = agc_pkg::RES_W;
    localparam int SW     = agc_pkg::SAMPLE_W;

    localparam logic [63:0]      ENV_RST64 = ((64'd1 << E) + 64'd5000) / 64'd10000;
    localparam logic [63:0]      EPS64     = ((64'd1 << E) + 64'd50000) / 64'd100000;
    localparam logic [E-1:0]     ENV_RST   = ENV_RST64[E-1:0];
    localparam logic [DVS_W-1:0] EPS       = EPS64[DVS_W-1:0];
    localparam logic [E-1:0]     ENV_MAX   = {E{1'b1}};
    localparam logic [POS_W-1:0] DEPTH_P   = POS_W'(D);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(D - 1);

    // limiter curve, built at elaboration
    logic [RW-1:0] rom_tbl [0:D];
    for (genvar k = 0; k <= D; k++)
    begin : g_rom
        localparam logic [63:0] ZK = (agc_pkg::DRIVE_Q30 * 64'(k)) / 64'(LIMITER_TABLE_DEPTH);
        localparam logic [RW-1:0] ENTRY = agc_pkg::lim_entry(ZK);
        assign rom_tbl[k] = ENTRY;
    end

    // register file
    logic [agc_pkg::COEF_W-1:0] attack_reg, release_reg;
    logic [agc_pkg::LVL_W-1:0]  target_reg, makeup_reg, maxg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= agc_pkg::ATTACK_RST;
            release_reg <= agc_pkg::RELEASE_RST;
            target_reg  <= agc_pkg::TARGET_RST;
            makeup_reg  <= agc_pkg::MAKEUP_RST;
            maxg_reg    <= agc_pkg::MAXGAIN_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                agc_pkg::CFG_ATTACK:  attack_reg  <= cfg.data;
                agc_pkg::CFG_RELEASE: release_reg <= cfg.data;
                agc_pkg::CFG_TARGET:  target_reg  <= cfg.data[agc_pkg::LVL_W-1:0];
                agc_pkg::CFG_MAKEUP:  makeup_reg  <= cfg.data[agc_pkg::LVL_W-1:0];
                agc_pkg::CFG_MAXGAIN: maxg_reg    <= cfg.data[agc_pkg::LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath state
    agc_pkg::state_t            state_reg, state_next;
    logic [E-1:0]               env_reg, env_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SW-1:0]              out_data_reg, out_data_next;
    logic                       neg_reg, neg_next;
    logic [SW-1:0]              mag_reg, mag_next;
    logic [MW-1:0]              acc_reg, acc_next;
    logic [MW-1:0]              mcand_reg, mcand_next;
    logic [agc_pkg::COEF_W-1:0] mplier_reg, mplier_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       sat_reg, sat_next;
    logic [agc_pkg::LVL_FRAC-1:0] u_reg, u_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [agc_pkg::LVL_FRAC-1:0] fr_reg, fr_next;
    logic [RW-1:0]              lo_reg, lo_next;
    logic [RW-1:0]              hi_reg, hi_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [RW-1:0]              res_reg, res_next;

    // combinational helpers
    logic [SW-1:0]              in_mag;
    logic [E-1:0]               in_a;
    logic [MW-1:0]              acc_step;
    logic [E-1:0]               env_new;
    logic                       div_start;
    logic                       div_done;
    logic [DVD_W-1:0]           div_quot;
    logic [DVD_W-1:0]           gain_lo;
    logic [agc_pkg::LVL_W-1:0]  gain;
    logic [POS_W-1:0]           pos;
    logic [IDX_W-1:0]           pos_idx;
    logic [IDX_W-1:0]           idx_p1;
    logic [RW-1:0]              step;
    logic [PROD_W:0]            rnd;
    logic [RW+1:0]              sum;
    logic                       out_free;

    agc_sdiv #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_sdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend({target_reg, (E - 8)'(0)}),
        .divisor ({1'b0, env_new} + EPS),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= agc_pkg::S_IDLE;
            env_reg       <= ENV_RST;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            env_reg       <= env_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        sat_reg      <= sat_next;
        u_reg        <= u_next;
        idx_reg      <= idx_next;
        fr_reg       <= fr_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        // magnitude; the most negative sample gives 0x8000
        in_mag = smp_in.sample_in[SW-1] ? SW'(~smp_in.sample_in + 1'b1) : smp_in.sample_in;
        // envelope-domain magnitude, saturating only for the full-scale negative case
        in_a   = in_mag[SW-1] ? ENV_MAX : {in_mag[SW-2:0], (E - 15)'(0)};

        acc_step = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
        env_new  = (|acc_reg[MW-1:E+24]) ? ENV_MAX : acc_reg[E+23:24];

        // gain clamp: floor at unity first, then the ceiling wins
        gain_lo = (div_quot < DVD_W'(agc_pkg::GAIN_MIN)) ? DVD_W'(agc_pkg::GAIN_MIN) : div_quot;
        gain    = (gain_lo > DVD_W'(maxg_reg)) ? maxg_reg : gain_lo[agc_pkg::LVL_W-1:0];

        pos     = {IDX_W'(0), u_reg} * DEPTH_P;
        pos_idx = pos[POS_W-1:agc_pkg::LVL_FRAC];
        idx_p1  = idx_reg + IDX_W'(1);
        step    = (hi_reg > lo_reg) ? (hi_reg - lo_reg) : '0;
        rnd     = {1'b0, prod_reg} + (PROD_W + 1)'(64'd1 << (agc_pkg::LVL_FRAC - 1));
        sum     = (RW + 2)'(lo_reg) + (RW + 2)'(rnd[PROD_W:agc_pkg::LVL_FRAC]);
        out_free = !out_valid_reg || smp_out.ready;

        state_next     = state_reg;
        env_next       = env_reg;
        out_valid_next = out_valid_reg && !smp_out.ready;
        out_data_next  = out_data_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        u_next         = u_reg;
        idx_next       = idx_reg;
        fr_next        = fr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        div_start      = 1'b0;
        smp_in.ready   = 1'b0;

        case (state_reg)
            agc_pkg::S_IDLE:
            begin
                smp_in.ready = 1'b1;
                if (smp_in.valid)
                begin
                    // env' * 2^24 = a * 2^24 + c * (env - a) + 2^23
                    neg_next    = smp_in.sample_in[SW-1];
                    mag_next    = in_mag;
                    mcand_next  = MW'(env_reg) - MW'(in_a);
                    acc_next    = (MW'(in_a) << 24) + (MW'(1) << 23);
                    mplier_next = (in_a > env_reg) ? attack_reg : release_reg;
                    cnt_next    = '0;
                    state_next  = agc_pkg::S_ENV_MUL;
                end
            end
            agc_pkg::S_ENV_MUL:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(agc_pkg::ENV_STEPS - 1))
                begin
                    state_next = agc_pkg::S_ENV_FIN;
                end
            end
            agc_pkg::S_ENV_FIN:
            begin
                // commit the envelope and launch gain = target / (env + eps)
                env_next   = env_new;
                div_start  = 1'b1;
                state_next = agc_pkg::S_DIV;
            end
            agc_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    acc_next    = '0;
                    mcand_next  = MW'(mag_reg);
                    mplier_next = agc_pkg::COEF_W'(gain);
                    cnt_next    = '0;
                    state_next  = agc_pkg::S_MUL1;
                end
            end
            agc_pkg::S_MUL1:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(agc_pkg::GAIN_STEPS - 1))
                begin
                    // reuse the product as the next multiplicand
                    acc_next    = '0;
                    mcand_next  = acc_step;
                    mplier_next = agc_pkg::COEF_W'(makeup_reg);
                    cnt_next    = '0;
                    state_next  = agc_pkg::S_MUL2;
                end
            end
            agc_pkg::S_MUL2:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(agc_pkg::GAIN_STEPS - 1))
                begin
                    sat_next   = |acc_step[MW-1:agc_pkg::LVL_FRAC];
                    u_next     = acc_step[agc_pkg::LVL_FRAC-1:0];
                    state_next = agc_pkg::S_POS;
                end
            end
            agc_pkg::S_POS:
            begin
                idx_next   = (pos_idx > IDX_LAST) ? IDX_LAST : pos_idx;
                fr_next    = pos[agc_pkg::LVL_FRAC-1:0];
                state_next = agc_pkg::S_ROM_LO;
            end
            agc_pkg::S_ROM_LO:
            begin
                lo_next    = rom_tbl[idx_reg];
                state_next = agc_pkg::S_ROM_HI;
            end
            agc_pkg::S_ROM_HI:
            begin
                hi_next    = rom_tbl[idx_p1];
                state_next = agc_pkg::S_INTERP;
            end
            agc_pkg::S_INTERP:
            begin
                prod_next  = PROD_W'(step) * PROD_W'(fr_reg);
                state_next = agc_pkg::S_ROUND;
            end
            agc_pkg::S_ROUND:
            begin
                // beyond the table span the limiter sits at full scale
                if (sat_reg || sum > (RW + 2)'(agc_pkg::RES_MAX))
                begin
                    res_next = agc_pkg::RES_MAX;
                end
                else
                begin
                    res_next = sum[RW-1:0];
                end
                state_next = agc_pkg::S_OUT;
            end
            agc_pkg::S_OUT:
            begin
                // hold until the output register frees
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = neg_reg ? SW'(~{1'b0, res_reg} + 1'b1) : {1'b0, res_reg};
                    state_next     = agc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = agc_pkg::S_IDLE;
            end
        endcase
    end

    assign smp_out.valid      = out_valid_reg;
    assign smp_out.sample_out = out_data_reg;

endmodule
`default_nettype wire

// ===== rtl/agc_chk.sv =====
`default_nettype none
module agc_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] sample_out
);
    // a waiting word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sample_out))
        else $error("output word changed while stalled");

    // one sample in flight: the input closes right after a take
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while one is in flight");

    // the limiter output is symmetric
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_out != 16'h8000)
        else $error("output reached the most negative code");

endmodule

bind agc_with_soft_limiter_top agc_chk u_agc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (smp_in.valid),
    .in_ready  (smp_in.ready),
    .out_valid (smp_out.valid),
    .out_ready (smp_out.ready),
    .sample_out(smp_out.sample_out)
);
`default_nettype wire

// ===== sim/agc_with_soft_limiter_top_tb.sv =====
`timescale 1ns / 1ps
module agc_with_soft_limiter_top_tb;

    localparam int  SAMPLE_W    = agc_pkg::SAMPLE_W;
    localparam int  RES_W       = agc_pkg::RES_W;
    localparam int  IDX_W       = agc_pkg::CFG_IDX_W;
    localparam int  DATA_W      = agc_pkg::CFG_DATA_W;
    localparam int  LVL_FRAC    = agc_pkg::LVL_FRAC;
    localparam int  ENV_BITS    = 24;
    localparam int  TABLE_DEPTH = 1024;
    localparam int  LATENCY     = 120;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam logic [63:0] ENV_MAX   = (64'd1 << ENV_BITS) - 64'd1;
    localparam logic [63:0] ENV_INIT  = ((64'd1 << ENV_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] ENV_EPS   = ((64'd1 << ENV_BITS) + 64'd50000) / 64'd100000;
    localparam logic [63:0] LVL_ONE   = 64'd1 << LVL_FRAC;
    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] DRIVE     = 64'd3006477107;
    // first index past the register list; writes there must be dropped
    localparam logic [IDX_W-1:0] CFG_NONE = agc_pkg::CFG_MAXGAIN + 3'd1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        bit                         known;   // expected word typed in below
        logic signed [SAMPLE_W-1:0] word;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    agc_in_if  smp_in();
    agc_out_if smp_out();
    agc_cfg_if cfg();

    agc_with_soft_limiter_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .smp_in  (smp_in.sink),
        .smp_out (smp_out.source),
        .cfg     (cfg.sink)
    );

    always #6 clk = ~clk;

    // Shadow of the block: registers, envelope and the limiter curve.
    logic [63:0] attack_r, release_r, target_r, makeup_r, maxgain_r, env_r;
    logic [RES_W-1:0] curve [0:TABLE_DEPTH];

    logic signed [SAMPLE_W-1:0] expected_words [$];
    logic signed [SAMPLE_W-1:0] typed_words [$];   // directed rows with a fixed answer
    bit   typed_mask [$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   steady = 1'b0;      // no idling on either side
    logic rx_block = 1'b0;    // long hold-off of the receiver

    // tanh in Q30: series on z/64, then six angle doublings
    function automatic logic [63:0] tanh_fix(input logic [63:0] z);
        logic [63:0] x, x2, x3, x5, x7, t;
        x  = (z + 64'd32) >> 6;
        x2 = (x * x) >> 30;
        x3 = (x2 * x) >> 30;
        x5 = (x3 * x2) >> 30;
        x7 = (x5 * x2) >> 30;
        t  = x - x3 / 64'd3;
        t  = t + (64'd2 * x5) / 64'd15;
        t  = t - (64'd17 * x7) / 64'd315;
        repeat (6)
        begin
            if (t > Q30_ONE) t = Q30_ONE;
            t = (t << 31) / (Q30_ONE + ((t * t) >> 30));
        end
        if (t > Q30_ONE) t = Q30_ONE;
        return t;
    endfunction

    function automatic void build_curve();
        logic [63:0] norm, v;
        norm = tanh_fix(DRIVE);
        if (norm == 64'd0) norm = 64'd1;
        for (int k = 0; k <= TABLE_DEPTH; k++)
        begin
            v = (tanh_fix((DRIVE * k) / TABLE_DEPTH) * 64'd32767 + norm / 64'd2) / norm;
            if (v > 64'd32767) v = 64'd32767;
            curve[k] = v[RES_W-1:0];
        end
    endfunction

    function automatic void load_defaults();
        attack_r  = 64'(agc_pkg::ATTACK_RST);
        release_r = 64'(agc_pkg::RELEASE_RST);
        target_r  = 64'(agc_pkg::TARGET_RST);
        makeup_r  = 64'(agc_pkg::MAKEUP_RST);
        maxgain_r = 64'(agc_pkg::MAXGAIN_RST);
        env_r     = ENV_INIT;
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] data);
        case (idx)
            agc_pkg::CFG_ATTACK:  attack_r  = 64'(data);
            agc_pkg::CFG_RELEASE: release_r = 64'(data);
            agc_pkg::CFG_TARGET:  target_r  = 64'(data[15:0]);
            agc_pkg::CFG_MAKEUP:  makeup_r  = 64'(data[15:0]);
            agc_pkg::CFG_MAXGAIN: maxgain_r = 64'(data[15:0]);
            default: ;
        endcase
    endfunction

    // Advance the envelope and return the limited output word.
    function automatic logic signed [SAMPLE_W-1:0] limit_sample(
        input logic signed [SAMPLE_W-1:0] s);
        logic [63:0] mag, lvl, c, gain, u, pos, idx, fr, lo, hi, slope, res;
        logic        neg;
        neg = s[SAMPLE_W-1];
        mag = neg ? (64'h10000 - {48'd0, s}) : {48'd0, s};
        lvl = mag << (ENV_BITS - 15);
        if (lvl > ENV_MAX) lvl = ENV_MAX;
        c = (lvl > env_r) ? attack_r : release_r;
        env_r = (c * env_r + (64'h1000000 - c) * lvl + 64'h800000) >> 24;
        if (env_r > ENV_MAX) env_r = ENV_MAX;
        gain = (target_r << (ENV_BITS - 8)) / (env_r + ENV_EPS);
        if (gain < 64'd256) gain = 64'd256;
        if (gain > maxgain_r) gain = maxgain_r;
        u = mag * gain * makeup_r;
        if (u >= LVL_ONE)
        begin
            res = 64'd32767;
        end
        else
        begin
            pos = u * TABLE_DEPTH;
            idx = pos >> LVL_FRAC;
            fr  = pos & (LVL_ONE - 64'd1);
            if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
            lo = curve[idx];
            hi = curve[idx + 1];
            slope = (hi > lo) ? hi - lo : 64'd0;
            res = lo + ((slope * fr + (64'd1 << (LVL_FRAC - 1))) >> LVL_FRAC);
            if (res > 64'd32767) res = 64'd32767;
        end
        return neg ? -$signed(res[15:0]) : $signed(res[15:0]);
    endfunction

    // Predict on every accepted sample word; track register writes as they land.
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] w;
        if (rst_n && smp_in.valid && smp_in.ready)
        begin
            w = limit_sample(smp_in.sample_in);
            // a typed-in answer replaces the prediction for directed rows
            if (typed_mask.size() != 0)
            begin
                if (typed_mask.pop_front()) w = typed_words.pop_front();
            end
            expected_words.push_back(w);
        end
        if (rst_n && cfg.valid && cfg.ready)
            apply_reg(cfg.index, cfg.data);
    end

    // Check every accepted output word against the oldest expectation.
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n && smp_out.valid && smp_out.ready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: sample_out=%0d", smp_out.sample_out);
            end
            else
            begin
                want = expected_words.pop_front();
                if (smp_out.sample_out !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample_out mismatch: expected %0d, got %0d",
                                 want, smp_out.sample_out);
                end
            end
        end
    end

    // Receiver: idle at random unless steady, and drop ready entirely during a hold-off.
    always @(posedge clk)
    begin
        smp_out.ready <= !rx_block && (steady || $urandom_range(99) >= 28);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one sample word; valid stays high across back-to-back words.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        if (!steady && $urandom_range(99) < 28)
        begin
            smp_in.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 28);
        end
        smp_in.valid     <= 1'b1;
        smp_in.sample_in <= s;
        do @(posedge clk); while (!smp_in.ready);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
    endtask

    // Drop valid, let every expected word come back, then let the pipeline settle.
    task automatic drain();
        smp_in.valid <= 1'b0;
        cfg.valid    <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Random sample: magnitude spread over all bit widths, now and then the most negative.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int k;
        logic [SAMPLE_W-1:0] r;
        if ($urandom_range(49) == 0) return 16'sh8000;
        k = $urandom_range(SAMPLE_W - 1);
        r = 16'($urandom);
        r = r & ((16'd1 << (k + 1)) - 16'd1);
        // sign-extend from bit k so quiet passages stay quiet
        if (r[k]) r = r | ~((16'd1 << (k + 1)) - 16'd1);
        return $signed(r);
    endfunction

    // Random passage: loud bursts and quiet tails to walk attack and release.
    task automatic random_passage(input int count);
        int left;
        int burst;
        int shift;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(40, 5);
            shift = $urandom_range(12);
            for (int i = 0; i < burst && left > 0; i++, left--)
            begin
                if ($urandom_range(3) == 0)
                    send_sample(pick_sample());
                else
                    send_sample(pick_sample() >>> shift);
            end
        end
    endtask

    stim_row_t directed [] = '{
        '{16'sd0,      1'b1, 16'sd0},       // silence after reset
        '{16'sh8000,   1'b1, -16'sd32767},  // most negative: limiter saturates
        '{16'sd32767,  1'b1, 16'sd32767},   // full scale positive saturates
        '{16'sd0,      1'b1, 16'sd0},
        '{16'sd1,      1'b0, 16'sd0},
        '{-16'sd1,     1'b0, 16'sd0},
        '{16'sd3,      1'b0, 16'sd0},
        '{16'sd100,    1'b0, 16'sd0},
        '{-16'sd100,   1'b0, 16'sd0},
        '{16'sd1000,   1'b0, 16'sd0},
        '{-16'sd4000,  1'b0, 16'sd0},
        '{16'sd12000,  1'b0, 16'sd0},
        '{16'sh5555,   1'b0, 16'sd0},
        '{-16'sh5556,  1'b0, 16'sd0},
        '{16'sd2,      1'b0, 16'sd0},
        '{16'sd0,      1'b0, 16'sd0},
        '{16'sd7,      1'b0, 16'sd0},
        '{-16'sd2,     1'b0, 16'sd0}
    };

    initial
    begin
        smp_in.valid     = 1'b0;
        smp_in.sample_in = '0;
        cfg.valid        = 1'b0;
        cfg.index        = agc_pkg::CFG_ATTACK;
        cfg.data         = '0;
        build_curve();
        load_defaults();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at reset defaults.
        foreach (directed[i])
        begin
            typed_mask.push_back(directed[i].known);
            if (directed[i].known) typed_words.push_back(directed[i].word);
        end
        foreach (directed[i])
            send_sample(directed[i].sample);
        drain();

        // Defaults, random passage, with a long receiver hold-off to fill the block.
        rx_block <= 1'b1;
        fork
            begin
                repeat (800) @(posedge clk);
                rx_block <= 1'b0;
            end
        join_none
        random_passage(300);
        drain();

        // Zero coefficients: the envelope jumps straight to the magnitude.
        write_reg(agc_pkg::CFG_ATTACK, 24'd0);
        write_reg(agc_pkg::CFG_RELEASE, 24'd0);
        write_reg(agc_pkg::CFG_TARGET, 24'd3277);
        write_reg(agc_pkg::CFG_MAKEUP, 24'd819);
        write_reg(agc_pkg::CFG_MAXGAIN, 24'd256);
        write_reg(CFG_NONE, 24'hFFFFFF);     // dropped
        drain();
        random_passage(250);
        drain();

        // Maximum coefficients and gains, run without idling.
        write_reg(agc_pkg::CFG_ATTACK, 24'hFFFFFF);
        write_reg(agc_pkg::CFG_RELEASE, 24'hFFFFFF);
        write_reg(agc_pkg::CFG_TARGET, 24'd52429);
        write_reg(agc_pkg::CFG_MAKEUP, 24'd32768);
        write_reg(agc_pkg::CFG_MAXGAIN, 24'd32768);
        drain();
        steady = 1'b1;
        random_passage(300);
        drain();
        steady = 1'b0;

        // Upper gain clamp below unity, top register bits set.
        write_reg(agc_pkg::CFG_MAXGAIN, 24'hFF0064);
        write_reg(agc_pkg::CFG_TARGET, 24'hAAFFFF);
        write_reg(agc_pkg::CFG_MAKEUP, 24'h12FFFF);
        write_reg(CFG_NONE + 3'd2, 24'd0);   // dropped
        drain();
        random_passage(250);
        drain();

        // Several fully random register settings.
        repeat (4)
        begin
            write_reg(agc_pkg::CFG_ATTACK, 24'($urandom));
            write_reg(agc_pkg::CFG_RELEASE, 24'($urandom));
            write_reg(agc_pkg::CFG_TARGET, 24'($urandom_range(52429, 3277)));
            write_reg(agc_pkg::CFG_MAKEUP, 24'($urandom_range(32768, 819)));
            write_reg(agc_pkg::CFG_MAXGAIN, 24'($urandom_range(32768, 256)));
            drain();
            random_passage(200);
            drain();
        end

        if (mismatches == 0 && expected_words.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
